[src/ps2kbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// Shared types, scan code constants and key map tables for the set 1 decoder.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

  localparam int CMD_QUEUE_DEPTH_DEF = 32;

  // Scan codes (set 1) and keyboard responses
  localparam logic [7:0] SC_TAB         = 8'h0F;
  localparam logic [7:0] SC_F11         = 8'h57;
  localparam logic [7:0] SC_KEY_C       = 8'h2E;
  localparam logic [7:0] SC_F2          = 8'h3C;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
  localparam logic [7:0] SC_CAPS_LOCK   = 8'h3A;
  localparam logic [7:0] SC_NUM_LOCK    = 8'h45;
  localparam logic [7:0] SC_SCROLL_LOCK = 8'h46;
  localparam logic [7:0] RSP_ACK        = 8'hFA;
  localparam logic [7:0] RSP_RESEND     = 8'hFE;
  localparam logic [7:0] CMD_SET_LEDS   = 8'hED;

  // LED bit masks
  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  // Hotkey event codes
  localparam logic [7:0] HK_TAB         = 8'd0;
  localparam logic [7:0] HK_F11         = 8'd1;
  localparam logic [7:0] HK_BREAK       = 8'd2;
  localparam logic [7:0] HK_NEW_CONSOLE = 8'd3;

  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_CASE    = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_HOTKEY = 2'd2
  } kind_t;

  // Per-item sequencer steps: send queued byte, character, event/queue update
  typedef enum logic [1:0] {
    PH_SEND  = 2'd0,
    PH_CHAR  = 2'd1,
    PH_EVENT = 2'd2
  } phase_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_byte;
  } q_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head_byte;
  } q_stat_t;

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h40, 8'h5B, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
    8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFTED_MAP [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h60, 8'h7B, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
    8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
  };

endpackage

[src/ps2_scancode_keyboard_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_keyboard_decoder_core
// Scan code set 1 decoder with modifier tracking, lock LEDs and a queue of
// LED command bytes sent to the keyboard.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                         Word contents
//  --------  ---  ------------------------------  ----------------------------
//  s_axis    in   tvalid/tready/tdata[7:0]        scan_code
//  m_axis    out  tvalid/tready/tdata/tuser/tlast tdata=value, tuser=kind,
//                                                 tlast=last
//  cfg       in   valid/ready/data[2:0]           initial_leds
//
//  Each byte passes through three sequencer steps: one sends the queued
//  command byte, one the character, one the hotkey or resend.
//  These steps set the rate; at most one result leaves per step.
//  Output stalls hold the sequencer at a step that has a word to emit.
//  A new byte is taken in the cycle the previous one finishes its last step.
//  rst (synchronous) clears modifiers, LEDs, the wait flag and the queue;
//  queue memory contents are not cleared.
//
module ps2_scancode_keyboard_decoder_core #(
  parameter int CMD_QUEUE_DEPTH = ps2kbd_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // scan byte in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
  // decoded word out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] value
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast,   // last word for this scan byte
  // LED preset
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data        // [2:0] initial_leds
);
  import ps2kbd_pkg::*;

  // Byte under work
  logic       in_valid;
  logic [7:0] in_code;
  phase_t     phase;
  phase_t     phase_next;

  // Keyboard state
  logic [1:0] shift_bits;
  logic       ctrl_down;
  logic [2:0] led_bits;
  logic       wait_valid;
  logic [7:0] wait_byte;

  q_ctrl_t    q_ctrl;
  q_stat_t    q_stat;

  // Decode of the held byte
  logic       is_lock;
  logic [2:0] lock_mask;
  logic [7:0] ch_raw;
  logic [7:0] ch;
  logic       char_go;
  logic       hk_go;
  logic [7:0] hk_code;
  logic       rs_go;
  logic       pop_go;

  // Current step
  logic       emit;
  kind_t      e_kind;
  logic [7:0] e_value;
  logic       e_last;
  logic       out_free;
  logic       step_ok;
  logic       item_done;

  assign cfg_ready = 1'b1;

  ps2kbd_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (q_ctrl),
    .stat (q_stat)
  );

  // A queued byte goes out only when nothing awaits acknowledge.
  assign pop_go = !q_stat.empty && !wait_valid;

  // Character lookup; break codes and responses never map.
  always_comb begin
    ch_raw = in_code[7] ? 8'h00
           : ((shift_bits != 2'b00) ? SHIFTED_MAP[in_code[6:0]]
                                    : PLAIN_MAP[in_code[6:0]]);
    ch = ch_raw;
    // Lower case unless exactly one of shift and caps lock is active
    if (ch_raw >= CHR_UPPER_A && ch_raw <= CHR_UPPER_Z &&
        (led_bits[2] == (shift_bits != 2'b00))) begin
      ch = ch_raw + CHR_CASE;
    end
  end
  assign char_go = (ch != 8'h00);

  always_comb begin
    hk_go     = 1'b0;
    hk_code   = HK_TAB;
    is_lock   = 1'b0;
    lock_mask = LED_SCROLL;
    case (in_code)
      SC_TAB: begin
        hk_go = 1'b1;
      end
      SC_F11: begin
        hk_go   = 1'b1;
        hk_code = HK_F11;
      end
      SC_KEY_C: begin
        hk_go   = ctrl_down;
        hk_code = HK_BREAK;
      end
      SC_F2: begin
        hk_go   = (shift_bits != 2'b00);
        hk_code = HK_NEW_CONSOLE;
      end
      SC_CAPS_LOCK: begin
        is_lock   = 1'b1;
        lock_mask = LED_CAPS;
      end
      SC_NUM_LOCK: begin
        is_lock   = 1'b1;
        lock_mask = LED_NUM;
      end
      SC_SCROLL_LOCK: begin
        is_lock = 1'b1;
      end
      default: begin
        hk_go = 1'b0;
      end
    endcase
  end

  // Resend covers a byte popped earlier in this same item as well.
  assign rs_go = (in_code == RSP_RESEND) && (wait_valid || pop_go);

  // Word of the current step; lock keys emit nothing, they update the queue.
  always_comb begin
    emit    = 1'b0;
    e_kind  = KIND_CMD;
    e_value = q_stat.head_byte;
    e_last  = 1'b1;
    case (phase)
      PH_SEND: begin
        emit    = pop_go;
        e_kind  = KIND_CMD;
        e_value = q_stat.head_byte;
        e_last  = !(char_go || hk_go || rs_go);
      end
      PH_CHAR: begin
        emit    = char_go;
        e_kind  = KIND_CHAR;
        e_value = ch;
        e_last  = !(hk_go || rs_go);
      end
      PH_EVENT: begin
        emit    = hk_go || rs_go;
        e_kind  = hk_go ? KIND_HOTKEY : KIND_CMD;
        e_value = hk_go ? hk_code : wait_byte;
        e_last  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign step_ok   = in_valid && (!emit || out_free);
  assign item_done = step_ok && (phase == PH_EVENT);

  assign s_axis_tready = !in_valid || item_done;

  // Queue traffic: pop on send, LED command then LED byte on a lock key
  always_comb begin
    q_ctrl.pop       = step_ok && (phase == PH_SEND) && pop_go;
    q_ctrl.push      = step_ok && is_lock && (phase == PH_CHAR || phase == PH_EVENT);
    q_ctrl.push_byte = (phase == PH_CHAR) ? CMD_SET_LEDS : {5'b00000, led_bits};
  end

  // Sequencer
  always_comb begin
    phase_next = phase;
    if (step_ok) begin
      case (phase)
        PH_SEND:  phase_next = PH_CHAR;
        PH_CHAR:  phase_next = PH_EVENT;
        PH_EVENT: phase_next = PH_SEND;
        default:  phase_next = PH_SEND;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEND;
    end else begin
      phase <= phase_next;
    end
  end

  // Input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (item_done) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_code <= s_axis_tdata;
    end
  end

  // Keyboard state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits <= 2'b00;
      ctrl_down  <= 1'b0;
      led_bits   <= 3'b000;
      wait_valid <= 1'b0;
      wait_byte  <= 8'h00;
    end else begin
      if (q_ctrl.pop) begin
        wait_valid <= 1'b1;
        wait_byte  <= q_stat.head_byte;
      end
      if (step_ok && phase == PH_CHAR && is_lock) begin
        led_bits <= led_bits ^ lock_mask;
      end
      if (item_done) begin
        case (in_code)
          SC_LSHIFT_MAKE: shift_bits[0] <= 1'b1;
          SC_RSHIFT_MAKE: shift_bits[1] <= 1'b1;
          SC_LSHIFT_BRK:  shift_bits[0] <= 1'b0;
          SC_RSHIFT_BRK:  shift_bits[1] <= 1'b0;
          SC_CTRL_MAKE:   ctrl_down     <= 1'b1;
          SC_CTRL_BRK:    ctrl_down     <= 1'b0;
          RSP_ACK:        wait_valid    <= 1'b0;
          default:        ctrl_down     <= ctrl_down;
        endcase
      end
      // The user sends presets only while idle (unenforced); LEDs load directly
      if (cfg_valid && cfg_ready) begin
        led_bits <= cfg_data;
      end
    end
  end

  // Output register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid && emit) begin
      m_axis_tdata <= e_value;
      m_axis_tuser <= e_kind;
      m_axis_tlast <= e_last;
    end
  end

endmodule

[src/ps2kbd_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kbd_cmd_queue
// Circular queue of keyboard command bytes in a synchronous memory. The head
// entry is read ahead into a register; a write to that entry is forwarded.
// ----------------------------------------------------------------------------
module ps2kbd_cmd_queue #(
  parameter int DEPTH = ps2kbd_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ps2kbd_pkg::q_ctrl_t ctrl,
  output ps2kbd_pkg::q_stat_t stat
);
  import ps2kbd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_data;
  logic             fwd;
  logic [7:0]       fwd_data;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == DEPTH_CNT);
  assign stat.head_byte = fwd ? fwd_data : rd_data;

  // count < DEPTH whenever a write is taken, so its low bits suffice
  assign tail_sum = {1'b0, head} + {1'b0, count[PTR_W-1:0]};
  assign tail     = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                            : tail_sum[PTR_W-1:0];

  assign wr_en = ctrl.push && !stat.full;
  assign rd_en = ctrl.pop && !stat.empty;

  always_comb begin
    head_next  = head;
    count_next = count;
    if (rd_en) begin
      head_next = (head == LAST_PTR) ? '0 : head + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      fwd   <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      fwd   <= wr_en && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= ctrl.push_byte;
    end
    rd_data  <= mem[head_next];
    fwd_data <= ctrl.push_byte;
  end

endmodule

[src/ps2kbd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kbd_checker
// Port-level checks for the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2kbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  import ps2kbd_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // A taken byte keeps the decoder busy, so input ready drops after a take
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a byte was taken");

  // Character words never carry a null code
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_CHAR) |-> m_axis_tdata != 8'h00)
    else $error("null character word");

  // Hotkey words carry one of four event codes and end their run
  a_hotkey_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_HOTKEY) |->
      (m_axis_tdata <= HK_NEW_CONSOLE) && m_axis_tlast)
    else $error("bad hotkey word");

endmodule

bind ps2_scancode_keyboard_decoder_core ps2kbd_checker u_ps2kbd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the set 1 scan code decoder word by word against a predictor that
// tracks shift, ctrl, lock LEDs, the acknowledge wait and the LED command
// queue. Directed key sequences come first, then random typing, modifier,
// lock and response traffic under several patterns of source gaps and sink
// stalls, with LED presets written between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ps2kbd_pkg::*;

  // Scan codes and responses the predictor reacts to
  localparam logic [7:0] KEY_TAB      = 8'h0F;
  localparam logic [7:0] KEY_F11      = 8'h57;
  localparam logic [7:0] KEY_C        = 8'h2E;
  localparam logic [7:0] KEY_F2       = 8'h3C;
  localparam logic [7:0] KEY_Q        = 8'h10;
  localparam logic [7:0] KEY_1        = 8'h02;
  localparam logic [7:0] KEY_BSLASH   = 8'h73;
  localparam logic [7:0] LSHIFT_DOWN  = 8'h2A;
  localparam logic [7:0] RSHIFT_DOWN  = 8'h36;
  localparam logic [7:0] LSHIFT_UP    = 8'hAA;
  localparam logic [7:0] RSHIFT_UP    = 8'hB6;
  localparam logic [7:0] CTRL_DOWN    = 8'h1D;
  localparam logic [7:0] CTRL_UP      = 8'h9D;
  localparam logic [7:0] CAPS_KEY     = 8'h3A;
  localparam logic [7:0] NUM_KEY      = 8'h45;
  localparam logic [7:0] SCROLL_KEY   = 8'h46;
  localparam logic [7:0] KBD_ACK      = 8'hFA;
  localparam logic [7:0] KBD_RESEND   = 8'hFE;
  localparam logic [7:0] SET_LEDS_CMD = 8'hED;

  // Hotkey event codes
  localparam logic [7:0] EV_TAB     = 8'd0;
  localparam logic [7:0] EV_F11     = 8'd1;
  localparam logic [7:0] EV_BREAK   = 8'd2;
  localparam logic [7:0] EV_CONSOLE = 8'd3;

  // LED bits: caps, num, scroll
  localparam logic [2:0] CAPS_LED   = 3'b100;
  localparam logic [2:0] NUM_LED    = 3'b010;
  localparam logic [2:0] SCROLL_LED = 3'b001;

  localparam int FIFO_DEPTH   = 32;
  localparam int PHASE_ITEMS  = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 6;
  localparam int MAX_REPORTS  = 10;

  // Key maps, 16 codes per string; 'a' marks a code with no character
  localparam byte NO_KEY = "a";
  string plain_keys = {
    "aa1234567890-^\010a", "QWERTYUIOP@[\naAS", "DFGHJKL;:aa]ZXCV",
    "BNM,./a*a aaaaaa", "aaaaaaa789-456+1", "230.aaaaaaaaaaaa",
    "aaaaaaaaaaaaaaaa", "aaa\134aaaaaaaaa\134aa"};
  string shift_keys = {
    "aa!\042#$%&'()~=~\010a", "QWERTYUIOP\140{\naAS", "DFGHJKL+*aa}ZXCV",
    "BNM<>?a*a aaaaaa", "aaaaaaa789-456+1", "230.aaaaaaaaaaaa",
    "aaaaaaaaaaaaaaaa", "aaa_aaaaaaaaa|aa"};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } kbd_word_t;

  // DUT ports, all inputs driven to known values from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = 3'b000;

  // Predicted keyboard state
  logic [1:0] shift_held = 2'b00;
  logic       ctrl_held  = 1'b0;
  logic [2:0] led_state  = 3'b000;
  logic       ack_wait   = 1'b0;
  logic [7:0] ack_byte   = 8'h00;
  logic [7:0] cmd_fifo [FIFO_DEPTH];
  logic [4:0] cmd_head   = 5'd0;
  int         cmd_count  = 0;

  kbd_word_t  pending_words [$];
  int         mismatch_count = 0;
  int         items_sent     = 0;
  int         cycle_count    = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct  = 0;

  ps2_scancode_keyboard_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bound the run; a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the output side at the rate of the current phase
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] key_char(input logic [6:0] code, input logic shifted);
    byte c;
    c = shifted ? shift_keys[code] : plain_keys[code];
    return (c == NO_KEY) ? 8'h00 : c;
  endfunction

  // Append one command byte unless the queue is full; each byte on its own
  function automatic void queue_cmd(input logic [7:0] b);
    logic [4:0] slot;
    if (cmd_count < FIFO_DEPTH) begin
      slot = cmd_head + 5'(cmd_count);
      cmd_fifo[slot] = b;
      cmd_count++;
    end
  endfunction

  // Work out the words that one accepted scan byte produces and queue them
  function automatic void decode_scan_byte(input logic [7:0] code);
    kind_t      kinds [3];
    logic [7:0] vals  [3];
    int         n;
    logic [7:0] ch;
    n  = 0;
    ch = 8'h00;

    // Send the oldest command byte first when nothing waits for an ack
    if (cmd_count > 0 && !ack_wait) begin
      ack_byte = cmd_fifo[cmd_head];
      cmd_head = cmd_head + 5'd1;
      cmd_count--;
      ack_wait = 1'b1;
      kinds[n] = KIND_CMD;
      vals[n]  = ack_byte;
      n++;
    end

    // Make codes map to a character; letters fold to lower case unless
    // exactly one of shift and caps lock is active
    if (!code[7]) ch = key_char(code[6:0], shift_held != 2'b00);
    if (ch >= "A" && ch <= "Z") begin
      if (((led_state & CAPS_LED) != 3'b000) == (shift_held != 2'b00)) ch = ch + 8'h20;
    end
    if (ch != 8'h00) begin
      kinds[n] = KIND_CHAR;
      vals[n]  = ch;
      n++;
    end

    case (code)
      KEY_TAB: begin
        kinds[n] = KIND_HOTKEY;
        vals[n]  = EV_TAB;
        n++;
      end
      KEY_F11: begin
        kinds[n] = KIND_HOTKEY;
        vals[n]  = EV_F11;
        n++;
      end
      KEY_C: begin
        if (ctrl_held) begin
          kinds[n] = KIND_HOTKEY;
          vals[n]  = EV_BREAK;
          n++;
        end
      end
      KEY_F2: begin
        if (shift_held != 2'b00) begin
          kinds[n] = KIND_HOTKEY;
          vals[n]  = EV_CONSOLE;
          n++;
        end
      end
      LSHIFT_DOWN: shift_held[0] = 1'b1;
      RSHIFT_DOWN: shift_held[1] = 1'b1;
      LSHIFT_UP:   shift_held[0] = 1'b0;
      RSHIFT_UP:   shift_held[1] = 1'b0;
      CTRL_DOWN:   ctrl_held = 1'b1;
      CTRL_UP:     ctrl_held = 1'b0;
      CAPS_KEY, NUM_KEY, SCROLL_KEY: begin
        led_state = led_state ^ ((code == CAPS_KEY) ? CAPS_LED :
                                 (code == NUM_KEY) ? NUM_LED : SCROLL_LED);
        queue_cmd(SET_LEDS_CMD);
        queue_cmd({5'b00000, led_state});
      end
      KBD_ACK: ack_wait = 1'b0;
      KBD_RESEND: begin
        // Resend only when a byte is actually waiting
        if (ack_wait) begin
          kinds[n] = KIND_CMD;
          vals[n]  = ack_byte;
          n++;
        end
      end
      default: ;
    endcase

    for (int i = 0; i < n; i++) pending_words.push_back('{kinds[i], vals[i], i == n - 1});
  endfunction

  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // Compare one output word against the oldest expectation
  function automatic void check_output_word();
    kbd_word_t want;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind=%0d value=%02h last=%0b",
                                m_axis_tuser, m_axis_tdata, m_axis_tlast));
    end else begin
      want = pending_words.pop_front();
      if (m_axis_tuser !== want.kind || m_axis_tdata !== want.value ||
          m_axis_tlast !== want.last)
        report_mismatch($sformatf(
          "expected kind=%0d value=%02h last=%0b, got kind=%0d value=%02h last=%0b",
          want.kind, want.value, want.last, m_axis_tuser, m_axis_tdata, m_axis_tlast));
    end
  endfunction

  // One monitor: preset writes, accepted scan bytes and output words, all
  // sampled at the same edge the DUT sees them
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) led_state = cfg_data;
      if (s_axis_tvalid && s_axis_tready) decode_scan_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_output_word();
    end
  end

  // Offer one scan byte, with random gaps ahead of it; return at acceptance
  task automatic send_scan(input logic [7:0] code);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Hold the source until every expected word is out, then let the last
  // byte finish its steps even if it produced nothing
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Write the LED preset while the block is idle
  task automatic write_leds(input logic [2:0] leds);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data  <= leds;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] any_lock_key();
    case ($urandom_range(2))
      0:       return CAPS_KEY;
      1:       return NUM_KEY;
      default: return SCROLL_KEY;
    endcase
  endfunction

  // Field extremes, every key class, acks and resends with and without a
  // waiting byte, and bytes that produce two words each
  task automatic test_directed();
    logic [7:0] seq [$];
    seq = '{8'h00, 8'hFF, 8'h7F, 8'h80, KEY_Q, KEY_1,
            LSHIFT_DOWN, KEY_1, KEY_Q, KEY_BSLASH, LSHIFT_UP, KEY_BSLASH,
            RSHIFT_DOWN, KEY_F2, RSHIFT_UP, KEY_F2,
            CAPS_KEY, KEY_Q, KBD_RESEND, KBD_ACK,
            CTRL_DOWN, KEY_C, CTRL_UP, KBD_ACK, KBD_RESEND,
            KEY_TAB, KEY_F11, NUM_KEY, SCROLL_KEY};
    foreach (seq[i]) send_scan(seq[i]);
  endtask

  // Press lock keys with no acks until the queue overflows (an odd fill
  // leaves a set-LEDs byte whose LED byte is dropped), then drain it
  task automatic test_lock_overflow();
    write_leds(3'($urandom_range(7)));
    send_scan(KBD_ACK);
    repeat (18) send_scan(any_lock_key());
    repeat (36) send_scan(($urandom_range(5) == 0) ? KBD_RESEND : KBD_ACK);
  endtask

  // One random sequence: mostly well-formed key traffic, some raw noise
  task automatic send_burst();
    logic [7:0] code;
    case ($urandom_range(9))
      0, 1, 2: begin
        repeat ($urandom_range(1, 4)) begin
          code = 8'($urandom_range(8'h7F));
          send_scan(code);
          if ($urandom_range(1)) send_scan(code | 8'h80);
        end
      end
      3: begin
        code = $urandom_range(1) ? LSHIFT_DOWN : RSHIFT_DOWN;
        send_scan(code);
        repeat ($urandom_range(1, 3)) send_scan(8'($urandom_range(8'h7F)));
        send_scan($urandom_range(1) ? LSHIFT_UP : RSHIFT_UP);
        if ($urandom_range(1)) send_scan(code == LSHIFT_DOWN ? LSHIFT_UP : RSHIFT_UP);
      end
      4: begin
        send_scan(CTRL_DOWN);
        send_scan($urandom_range(1) ? KEY_C : 8'($urandom_range(8'h7F)));
        send_scan(CTRL_UP);
      end
      5: begin
        send_scan(any_lock_key());
        if ($urandom_range(2) == 0) send_scan(KBD_RESEND);
        repeat ($urandom_range(1, 3)) send_scan(KBD_ACK);
      end
      6: begin
        case ($urandom_range(2))
          0: send_scan(KEY_TAB);
          1: send_scan(KEY_F11);
          default: begin
            send_scan(LSHIFT_DOWN);
            send_scan(KEY_F2);
            send_scan(LSHIFT_UP);
          end
        endcase
      end
      7: send_scan($urandom_range(1) ? KBD_ACK : KBD_RESEND);
      default: send_scan(8'($urandom_range(255)));
    endcase
  endtask

  // Random traffic under one gap/stall pattern; optionally hold the source
  // halfway until the output has caught up
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [2:0] leds, input bit pause_midway);
    int stop_at;
    write_leds(leds);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if (pause_midway && items_sent >= stop_at - PHASE_ITEMS / 2) begin
        wait_all_results();
        pause_midway = 1'b0;
      end
      send_burst();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_lock_overflow();
    test_random_traffic(0, 0, 3'b000, 1'b0);
    test_random_traffic(54, 0, 3'b111, 1'b1);
    test_random_traffic(0, 54, 3'($urandom_range(7)), 1'b0);
    test_random_traffic(21, 21, 3'($urandom_range(7)), 1'b0);

    wait_all_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/ps2kbd_pkg.sv
src/ps2kbd_cmd_queue.sv
src/ps2_scancode_keyboard_decoder_core.sv
src/ps2kbd_checker.sv
tb/testbench.sv
